### hdl/ipv4_tcp_header_parser_macros.svh
// assertion macros for the ipv4 tcp header parser
`ifndef IPV4_TCP_HEADER_PARSER_MACROS_SVH
`define IPV4_TCP_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define IHTP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ihtp assertion failed");

`define IHTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihtp assertion failed");

`define IHTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihtp assertion failed");

`else

`define IHTP_ASSERT(label, clk, rst, prop)

`define IHTP_ASSERT_IMPL(label, clk, rst, ante, cons)

`define IHTP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/ihtp_pkg.sv
// shared types and constants for the ipv4 tcp header parser
package ihtp_pkg;

   localparam int unsigned CaptureLimitDefault = 8192;
   localparam logic [15:0] HttpPortReset       = 16'd80;
   localparam logic [15:0] EthHdrBytes         = 16'd14;
   localparam logic [15:0] MinHdrBytes         = 16'd20;
   localparam logic [15:0] EthertypeIpv4       = 16'h0800;
   localparam logic [7:0]  ProtoTcp            = 8'd6;
   localparam logic [3:0]  IpVersion4          = 4'd4;
   localparam int          RspDataWidth        = 224;

   typedef enum logic [3:0] {
      STATUS_OK             = 4'd0,
      STATUS_SHORT_ETH      = 4'd1,
      STATUS_NOT_IPV4       = 4'd2,
      STATUS_SHORT_IP       = 4'd3,
      STATUS_BAD_VERSION    = 4'd4,
      STATUS_BAD_IHL        = 4'd5,
      STATUS_SHORT_IP_OPTS  = 4'd6,
      STATUS_NOT_TCP        = 4'd7,
      STATUS_SHORT_TCP      = 4'd8,
      STATUS_BAD_OFFSET     = 4'd9,
      STATUS_SHORT_TCP_OPTS = 4'd10,
      STATUS_BAD_TOTAL_LEN  = 4'd11
   } status_type;

   typedef struct packed {
      logic [15:0] count;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] ethertype;
      logic [7:0]  version_ihl;
      logic [15:0] total_len;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] tcp_src;
      logic [15:0] tcp_dst;
      logic [3:0]  data_offset;
   } frame_type;

   // first member in the highest bits, status ends up at bit 0
   typedef struct packed {
      logic [15:0] payload_bytes;
      logic [5:0]  tcp_hdr_bytes;
      logic [5:0]  ip_hdr_bytes;
      logic [15:0] tcp_dst;
      logic [15:0] tcp_src;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      status_type  status;
   } rsp_data_type;

endpackage

### hdl/ihtp_capture.sv
// per-byte header field capture and frame byte count
`include "ipv4_tcp_header_parser_macros.svh"

module ihtp_capture #(
   parameter int unsigned CAPTURE_LIMIT = ihtp_pkg::CaptureLimitDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          byte_data,
   input  logic                byte_last,
   input  logic                advance,
   output ihtp_pkg::frame_type frame,
   output logic                frame_done
);

   localparam logic [15:0] CountLimit = 16'(CAPTURE_LIMIT);

   ihtp_pkg::frame_type frame_ff, frame_in, base, upd;
   logic                done_ff, done_in;
   logic [15:0]         pos;
   logic [15:0]         tcp_base;

   always_comb begin
      base     = done_ff ? '0 : frame_ff;
      upd      = base;
      pos      = base.count;
      tcp_base = ihtp_pkg::EthHdrBytes + {10'd0, base.version_ihl[3:0], 2'b00};
      if (byte_valid && (base.count < CountLimit)) begin
         upd.count = base.count + 16'd1;
         if (pos < 16'd6) begin
            upd.dst_mac = {base.dst_mac[39:0], byte_data};
         end else if (pos < 16'd12) begin
            upd.src_mac = {base.src_mac[39:0], byte_data};
         end else if (pos < 16'd14) begin
            upd.ethertype = {base.ethertype[7:0], byte_data};
         end else if (pos == 16'd14) begin
            upd.version_ihl = byte_data;
         end else if ((pos == 16'd16) || (pos == 16'd17)) begin
            upd.total_len = {base.total_len[7:0], byte_data};
         end else if (pos == 16'd23) begin
            upd.protocol = byte_data;
         end else if ((pos >= 16'd26) && (pos < 16'd30)) begin
            upd.src_ip = {base.src_ip[23:0], byte_data};
         end else if ((pos >= 16'd30) && (pos < 16'd34)) begin
            upd.dst_ip = {base.dst_ip[23:0], byte_data};
         end
         // tcp fields follow the ip header, placed by the stored ihl
         if (pos > 16'd14) begin
            if ((pos == tcp_base) || (pos == tcp_base + 16'd1)) begin
               upd.tcp_src = {base.tcp_src[7:0], byte_data};
            end else if ((pos == tcp_base + 16'd2) || (pos == tcp_base + 16'd3)) begin
               upd.tcp_dst = {base.tcp_dst[7:0], byte_data};
            end else if (pos == tcp_base + 16'd12) begin
               upd.data_offset = byte_data[7:4];
            end
         end
      end
      if (done_ff && !advance) begin
         frame_in = frame_ff;
         done_in  = 1'b1;
      end else begin
         frame_in = upd;
         done_in  = byte_valid && byte_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         done_ff  <= done_in;
      end
   end

   assign frame      = frame_ff;
   assign frame_done = done_ff;

   `IHTP_ASSERT(a_count_limit, clock, reset, frame_ff.count <= CountLimit)
   `IHTP_ASSERT_NEXT(a_restart, clock, reset, done_ff && advance, frame_ff.count <= 16'd1)
   `IHTP_ASSERT_NEXT(a_hold_end, clock, reset, done_ff && !advance,
                     done_ff && $stable(frame_ff))

endmodule

### hdl/ihtp_check.sv
// end-of-frame checks, payload length and result register
`include "ipv4_tcp_header_parser_macros.svh"

module ihtp_check (
   input  logic                   clock,
   input  logic                   reset,
   input  ihtp_pkg::frame_type    frame,
   input  logic                   frame_done,
   input  logic [15:0]            http_port,
   input  logic                   rsp_ready,
   output logic                   advance,
   output logic                   rsp_valid,
   output ihtp_pkg::rsp_data_type rsp_data,
   output logic                   rsp_http
);

   logic [5:0]             ihl_bytes;
   logic [5:0]             tcp_bytes;
   logic [15:0]            ip_end;
   logic [15:0]            tcp_end;
   logic [15:0]            hdr_sum;
   logic [15:0]            pay_len;
   logic [15:0]            cap_left;
   logic [15:0]            pay;
   ihtp_pkg::status_type   status;
   ihtp_pkg::rsp_data_type data_in, rsp_data_ff;
   logic                   http_in, rsp_http_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ihl_bytes = {frame.version_ihl[3:0], 2'b00};
      tcp_bytes = {frame.data_offset, 2'b00};
      ip_end    = ihtp_pkg::EthHdrBytes + 16'(ihl_bytes);
      tcp_end   = ip_end + 16'(tcp_bytes);
      hdr_sum   = 16'(ihl_bytes) + 16'(tcp_bytes);
      if (frame.count < ihtp_pkg::EthHdrBytes) begin
         status = ihtp_pkg::STATUS_SHORT_ETH;
      end else if (frame.ethertype != ihtp_pkg::EthertypeIpv4) begin
         status = ihtp_pkg::STATUS_NOT_IPV4;
      end else if (frame.count < ihtp_pkg::EthHdrBytes + ihtp_pkg::MinHdrBytes) begin
         status = ihtp_pkg::STATUS_SHORT_IP;
      end else if (frame.version_ihl[7:4] != ihtp_pkg::IpVersion4) begin
         status = ihtp_pkg::STATUS_BAD_VERSION;
      end else if (16'(ihl_bytes) < ihtp_pkg::MinHdrBytes) begin
         status = ihtp_pkg::STATUS_BAD_IHL;
      end else if (frame.count < ip_end) begin
         status = ihtp_pkg::STATUS_SHORT_IP_OPTS;
      end else if (frame.protocol != ihtp_pkg::ProtoTcp) begin
         status = ihtp_pkg::STATUS_NOT_TCP;
      end else if (frame.count < ip_end + ihtp_pkg::MinHdrBytes) begin
         status = ihtp_pkg::STATUS_SHORT_TCP;
      end else if (16'(tcp_bytes) < ihtp_pkg::MinHdrBytes) begin
         status = ihtp_pkg::STATUS_BAD_OFFSET;
      end else if (frame.count < tcp_end) begin
         status = ihtp_pkg::STATUS_SHORT_TCP_OPTS;
      end else if (frame.total_len < hdr_sum) begin
         status = ihtp_pkg::STATUS_BAD_TOTAL_LEN;
      end else begin
         status = ihtp_pkg::STATUS_OK;
      end
      pay_len  = frame.total_len - hdr_sum;
      cap_left = frame.count - tcp_end;
      pay      = (pay_len > cap_left) ? cap_left : pay_len;
      data_in  = '0;
      http_in  = 1'b0;
      data_in.status = status;
      if (status == ihtp_pkg::STATUS_OK) begin
         data_in.dst_mac       = frame.dst_mac;
         data_in.src_mac       = frame.src_mac;
         data_in.src_ip        = frame.src_ip;
         data_in.dst_ip        = frame.dst_ip;
         data_in.tcp_src       = frame.tcp_src;
         data_in.tcp_dst       = frame.tcp_dst;
         data_in.ip_hdr_bytes  = ihl_bytes;
         data_in.tcp_hdr_bytes = tcp_bytes;
         data_in.payload_bytes = pay;
         http_in = (pay != 16'd0) &&
                   ((frame.tcp_src == http_port) || (frame.tcp_dst == http_port));
      end
   end

   assign advance      = frame_done && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= data_in;
         rsp_http_ff <= http_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_http  = rsp_http_ff;

   `IHTP_ASSERT_IMPL(a_http_payload, clock, reset, rsp_valid_ff && rsp_http_ff,
                     rsp_data_ff.payload_bytes != 16'd0)
   `IHTP_ASSERT_IMPL(a_fail_zero, clock, reset,
                     rsp_valid_ff && (rsp_data_ff.status != ihtp_pkg::STATUS_OK),
                     (rsp_data_ff.dst_mac == 48'd0) && (rsp_data_ff.src_ip == 32'd0) &&
                     (rsp_data_ff.payload_bytes == 16'd0) && !rsp_http_ff)
   `IHTP_ASSERT_NEXT(a_load_valid, clock, reset, advance, rsp_valid_ff)

endmodule

### hdl/ipv4_tcp_header_parser.sv
// top level: ethernet ipv4 tcp header parser with http port register
// the last byte sets the frame-done register; the result register loads from it once any earlier result is taken
// throughput: one byte per cycle while req_tready is high, next frame may start right after a last byte
// a stalled result holds req_tready low only while a further finished frame waits
// reset clears the frame state, the result valid and sets http_port to 80

module ipv4_tcp_header_parser #(
   parameter int unsigned CAPTURE_LIMIT = ihtp_pkg::CaptureLimitDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, dst_mac, src_mac, src_ip, dst_ip, tcp source port, tcp destination port,
   // ip_hdr_bytes, tcp_hdr_bytes, payload_bytes
   output logic [223:0] rsp_tdata,
   output logic         rsp_tuser,   // is_http
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data     // http_port
);

   logic [15:0]            http_port_reg_ff;
   logic                   accept;
   logic                   advance;
   logic                   frame_done;
   ihtp_pkg::frame_type    frame;
   ihtp_pkg::rsp_data_type rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         http_port_reg_ff <= ihtp_pkg::HttpPortReset;
      end else if (csr_valid && csr_ready) begin
         http_port_reg_ff <= csr_data;
      end
   end

   assign req_tready = !frame_done || advance;
   assign accept     = req_tvalid && req_tready;

   ihtp_capture #(
      .CAPTURE_LIMIT (CAPTURE_LIMIT)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .advance    (advance),
      .frame      (frame),
      .frame_done (frame_done)
   );

   ihtp_check u_check (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .frame_done (frame_done),
      .http_port  (http_port_reg_ff),
      .rsp_ready  (rsp_tready),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_data),
      .rsp_http   (rsp_tuser)
   );

   assign rsp_tdata = rsp_data;

endmodule

### test/tb.sv
// testbench for the ipv4 tcp header parser: directed and random frame streams checked by a header predictor
`timescale 1ns / 1ps

module tb;
   import ihtp_pkg::*;

   localparam int unsigned CaptureLimit   = CaptureLimitDefault;
   localparam int unsigned LongHoldCycles = 400;
   localparam int unsigned WatchdogLimit  = 5000;
   localparam int unsigned PhaseBytes     = 170;
   localparam int unsigned PhaseFrames    = 2;

   typedef enum int unsigned {
      PACE_FREE,
      PACE_RANDOM,
      PACE_PERIODIC,
      PACE_SPARSE
   } pace_type;

   typedef struct packed {
      rsp_data_type data;
      logic         http;
   } parsed_header_type;

   class frame_scoreboard;
      frame_type         fr;
      logic [15:0]       http_port;
      parsed_header_type expected_headers[$];
      int unsigned       error_count;

      function new();
         fr = '0;
         http_port = HttpPortReset;
         error_count = 0;
      endfunction

      function void set_http_port(logic [15:0] value);
         http_port = value;
      endfunction

      function int unsigned pending_count();
         return expected_headers.size();
      endfunction

      function parsed_header_type predict_header();
         parsed_header_type h;
         status_type        st;
         int unsigned       cap;
         int unsigned       iph;
         int unsigned       tcph;
         int unsigned       pay;
         int unsigned       room;
         cap = 32'(fr.count);
         iph = 32'(fr.version_ihl[3:0]) * 4;
         tcph = 32'(fr.data_offset) * 4;
         if (cap < 32'(EthHdrBytes)) st = STATUS_SHORT_ETH;
         else if (fr.ethertype != EthertypeIpv4) st = STATUS_NOT_IPV4;
         else if (cap < 32'(EthHdrBytes) + 32'(MinHdrBytes)) st = STATUS_SHORT_IP;
         else if (fr.version_ihl[7:4] != IpVersion4) st = STATUS_BAD_VERSION;
         else if (iph < 32'(MinHdrBytes)) st = STATUS_BAD_IHL;
         else if (cap < 32'(EthHdrBytes) + iph) st = STATUS_SHORT_IP_OPTS;
         else if (fr.protocol != ProtoTcp) st = STATUS_NOT_TCP;
         else if (cap < 32'(EthHdrBytes) + iph + 32'(MinHdrBytes)) st = STATUS_SHORT_TCP;
         else if (tcph < 32'(MinHdrBytes)) st = STATUS_BAD_OFFSET;
         else if (cap < 32'(EthHdrBytes) + iph + tcph) st = STATUS_SHORT_TCP_OPTS;
         else if (32'(fr.total_len) < iph + tcph) st = STATUS_BAD_TOTAL_LEN;
         else st = STATUS_OK;
         h.data = '0;
         h.http = 1'b0;
         h.data.status = st;
         if (st == STATUS_OK) begin
            pay = 32'(fr.total_len) - iph - tcph;
            room = cap - 32'(EthHdrBytes) - iph - tcph;
            if (pay > room) pay = room;
            h.data.dst_mac = fr.dst_mac;
            h.data.src_mac = fr.src_mac;
            h.data.src_ip = fr.src_ip;
            h.data.dst_ip = fr.dst_ip;
            h.data.tcp_src = fr.tcp_src;
            h.data.tcp_dst = fr.tcp_dst;
            h.data.ip_hdr_bytes = 6'(iph);
            h.data.tcp_hdr_bytes = 6'(tcph);
            h.data.payload_bytes = 16'(pay);
            h.http = (pay > 0) && (fr.tcp_src == http_port || fr.tcp_dst == http_port);
         end
         return h;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         int unsigned pos;
         int unsigned tcp_pos;
         if (32'(fr.count) < CaptureLimit) begin
            pos = 32'(fr.count);
            tcp_pos = 32'(EthHdrBytes) + 32'(fr.version_ihl[3:0]) * 4;
            if (pos < 6) fr.dst_mac = {fr.dst_mac[39:0], b};
            else if (pos < 12) fr.src_mac = {fr.src_mac[39:0], b};
            else if (pos < 14) fr.ethertype = {fr.ethertype[7:0], b};
            else if (pos == 14) fr.version_ihl = b;
            else if (pos == 16 || pos == 17) fr.total_len = {fr.total_len[7:0], b};
            else if (pos == 23) fr.protocol = b;
            else if (pos >= 26 && pos < 30) fr.src_ip = {fr.src_ip[23:0], b};
            else if (pos >= 30 && pos < 34) fr.dst_ip = {fr.dst_ip[23:0], b};
            // tcp fields follow the stored ihl, only past the version byte
            if (pos > 14) begin
               if (pos == tcp_pos || pos == tcp_pos + 1)
                  fr.tcp_src = {fr.tcp_src[7:0], b};
               else if (pos == tcp_pos + 2 || pos == tcp_pos + 3)
                  fr.tcp_dst = {fr.tcp_dst[7:0], b};
               else if (pos == tcp_pos + 12)
                  fr.data_offset = b[7:4];
            end
            fr.count = fr.count + 16'd1;
         end
         if (last) begin
            expected_headers.push_back(predict_header());
            fr = '0;
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         error_count++;
         $display("mismatch %s: got %0h expected %0h", what, got, want);
      endtask

      task check_header(logic [RspDataWidth-1:0] raw, logic user);
         rsp_data_type      got;
         parsed_header_type want;
         got = rsp_data_type'(raw);
         if (expected_headers.size() == 0) begin
            report_mismatch("unexpected transaction", raw[63:0], '0);
            return;
         end
         want = expected_headers.pop_front();
         if (got.status !== want.data.status)
            report_mismatch("status", 64'(got.status), 64'(want.data.status));
         if (got.dst_mac !== want.data.dst_mac)
            report_mismatch("dst_mac", 64'(got.dst_mac), 64'(want.data.dst_mac));
         if (got.src_mac !== want.data.src_mac)
            report_mismatch("src_mac", 64'(got.src_mac), 64'(want.data.src_mac));
         if (got.src_ip !== want.data.src_ip)
            report_mismatch("src_ip", 64'(got.src_ip), 64'(want.data.src_ip));
         if (got.dst_ip !== want.data.dst_ip)
            report_mismatch("dst_ip", 64'(got.dst_ip), 64'(want.data.dst_ip));
         if (got.tcp_src !== want.data.tcp_src)
            report_mismatch("tcp_src", 64'(got.tcp_src), 64'(want.data.tcp_src));
         if (got.tcp_dst !== want.data.tcp_dst)
            report_mismatch("tcp_dst", 64'(got.tcp_dst), 64'(want.data.tcp_dst));
         if (got.ip_hdr_bytes !== want.data.ip_hdr_bytes)
            report_mismatch("ip_hdr_bytes", 64'(got.ip_hdr_bytes),
                            64'(want.data.ip_hdr_bytes));
         if (got.tcp_hdr_bytes !== want.data.tcp_hdr_bytes)
            report_mismatch("tcp_hdr_bytes", 64'(got.tcp_hdr_bytes),
                            64'(want.data.tcp_hdr_bytes));
         if (got.payload_bytes !== want.data.payload_bytes)
            report_mismatch("payload_bytes", 64'(got.payload_bytes),
                            64'(want.data.payload_bytes));
         if (user !== want.http)
            report_mismatch("is_http", 64'(user), 64'(want.http));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [7:0]              req_tdata;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [15:0]             csr_data;

   frame_scoreboard sb = new();
   logic [7:0]      frame_bytes[$];
   logic [15:0]     port_setting = HttpPortReset;
   logic            long_hold_req = 1'b0;
   int unsigned     bytes_sent = 0;
   int unsigned     burst_left = 1;
   int unsigned     quiet_cycles = 0;

   ipv4_tcp_header_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_header(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (csr_valid && csr_ready) sb.set_http_port(csr_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_pacer
      pace_type    mode;
      int unsigned left;
      int unsigned tick;
      mode = PACE_FREE;
      left = 0;
      tick = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = pace_type'($urandom_range(0, 3));
               left = $urandom_range(16, 160);
            end
            left--;
            case (mode)
               PACE_FREE:     rsp_tready <= 1'b1;
               PACE_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
               PACE_PERIODIC: rsp_tready <= (tick % 4 == 0);
               default:       rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 16);
      end
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_http_port(input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      port_setting = value;
   endtask

   task automatic build_tcp_frame(input int unsigned ihl, input int unsigned off,
                                  input int unsigned pay_len, input logic [15:0] sport,
                                  input logic [15:0] dport, input logic [15:0] total_len);
      frame_bytes.delete();
      repeat (12) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(EthertypeIpv4[15:8]);
      frame_bytes.push_back(EthertypeIpv4[7:0]);
      frame_bytes.push_back({IpVersion4, 4'(ihl)});
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(total_len[15:8]);
      frame_bytes.push_back(total_len[7:0]);
      repeat (5) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(ProtoTcp);
      repeat (10) frame_bytes.push_back(8'($urandom));
      if (ihl > 5) repeat ((ihl - 5) * 4) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(sport[15:8]);
      frame_bytes.push_back(sport[7:0]);
      frame_bytes.push_back(dport[15:8]);
      frame_bytes.push_back(dport[7:0]);
      repeat (8) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({4'(off), 4'($urandom)});
      repeat (7) frame_bytes.push_back(8'($urandom));
      if (off > 5) repeat ((off - 5) * 4) frame_bytes.push_back(8'($urandom));
      repeat (pay_len) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic good_frame(input int unsigned ihl, input int unsigned off,
                             input int unsigned pay_len);
      build_tcp_frame(ihl, off, pay_len, 16'($urandom), 16'($urandom),
                      16'(ihl * 4 + off * 4 + pay_len));
   endtask

   task automatic truncate_frame(input int unsigned keep);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
   endtask

   task automatic run_directed();
      frame_bytes.delete();
      frame_bytes.push_back(8'hff);
      send_frame();
      frame_bytes.delete();
      repeat (13) frame_bytes.push_back(8'($urandom));
      send_frame();
      frame_bytes.delete();
      repeat (14) frame_bytes.push_back(8'hff);
      send_frame();
      good_frame(5, 5, 10);
      truncate_frame(20);
      send_frame();
      good_frame(5, 5, 10);
      frame_bytes[14] = 8'h65;
      send_frame();
      good_frame(5, 5, 10);
      frame_bytes[14] = 8'h44;
      send_frame();
      good_frame(5, 5, 10);
      frame_bytes[14] = 8'h40;
      send_frame();
      good_frame(15, 5, 4);
      truncate_frame(73);
      send_frame();
      good_frame(5, 5, 10);
      frame_bytes[23] = 8'd17;
      send_frame();
      good_frame(5, 5, 0);
      truncate_frame(53);
      send_frame();
      good_frame(5, 5, 8);
      frame_bytes[46] = 8'h0f;
      send_frame();
      good_frame(5, 15, 0);
      truncate_frame(93);
      send_frame();
      build_tcp_frame(5, 5, 6, 16'($urandom), 16'($urandom), 16'd39);
      send_frame();
      build_tcp_frame(5, 5, 10, 16'($urandom), HttpPortReset, 16'd50);
      send_frame();
      build_tcp_frame(5, 5, 0, HttpPortReset, 16'($urandom), 16'd40);
      send_frame();
      build_tcp_frame(5, 5, 30, 16'($urandom), 16'($urandom), 16'hffff);
      send_frame();
      build_tcp_frame(15, 15, 20, 16'hffff, 16'hffff, 16'hffff);
      for (int i = 0; i < 12; i++) frame_bytes[i] = 8'hff;
      for (int i = 26; i < 34; i++) frame_bytes[i] = 8'hff;
      send_frame();
      build_tcp_frame(5, 5, 8, HttpPortReset, HttpPortReset, 16'd40);
      send_frame();
      frame_bytes.delete();
      repeat (60) frame_bytes.push_back(8'h00);
      send_frame();
   endtask

   task automatic random_frame();
      int unsigned ihl;
      int unsigned off;
      int unsigned pay;
      int unsigned kind;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] total;
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      off = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      pay = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
      sport = 16'($urandom);
      dport = 16'($urandom);
      case ($urandom_range(0, 5))
         0:       sport = port_setting;
         1:       dport = port_setting;
         default: ;
      endcase
      total = 16'(ihl * 4 + off * 4 + pay);
      case ($urandom_range(0, 7))
         0:       total = total + 16'($urandom_range(1, 600));
         1:       total = 16'($urandom_range(0, total));
         2:       total = 16'hffff;
         default: ;
      endcase
      build_tcp_frame(ihl, off, pay, sport, dport, total);
      kind = $urandom_range(0, 99);
      if (kind >= 96) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
      end else if (kind >= 89) begin
         truncate_frame($urandom_range(1, frame_bytes.size()));
      end else if (kind >= 85) begin
         frame_bytes[26 + ihl * 4] = {4'($urandom_range(0, 4)), frame_bytes[26 + ihl * 4][3:0]};
      end else if (kind >= 81) begin
         frame_bytes[23] = 8'($urandom);
      end else if (kind >= 77) begin
         frame_bytes[14] = {frame_bytes[14][7:4], 4'($urandom_range(0, 4))};
      end else if (kind >= 73) begin
         frame_bytes[14] = {4'($urandom), frame_bytes[14][3:0]};
      end else if (kind >= 69) begin
         frame_bytes[12] = 8'($urandom);
         frame_bytes[13] = 8'($urandom);
      end
   endtask

   task automatic run_random_phase();
      int unsigned start_bytes;
      int unsigned frames;
      start_bytes = bytes_sent;
      frames = 0;
      while (bytes_sent - start_bytes < PhaseBytes || frames < PhaseFrames) begin
         random_frame();
         send_frame();
         frames++;
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random_phase();
      write_http_port(16'h0000);
      long_hold_req = 1'b1;
      repeat (8) begin
         frame_bytes.delete();
         frame_bytes.push_back(8'($urandom));
         send_frame();
      end
      run_random_phase();
      write_http_port(16'hffff);
      run_random_phase();
      write_http_port(16'($urandom));
      run_random_phase();
      write_http_port(HttpPortReset);
      run_random_phase();
      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_count() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### ipv4_tcp_header_parser.f
+incdir+hdl
hdl/ihtp_pkg.sv
hdl/ihtp_capture.sv
hdl/ihtp_check.sv
hdl/ipv4_tcp_header_parser.sv
test/tb.sv
